>>> rtl/pbin_pkg.sv
// ----------------------------------------------------------------------------
// pbin_pkg
// Shared types and constants of the per-second packet binning block.
// ----------------------------------------------------------------------------
package pbin_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_BATCH    = 32;
    localparam int SEC_W        = 32;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 6;

    localparam logic [CFG_W-1:0] FLUSH_OCC_RST  = 6'd20;
    localparam logic [CFG_W-1:0] BATCH_SIZE_RST = 6'd10;

    // configuration register indexes
    typedef enum logic {
        REG_FLUSH_OCC  = 1'b0,
        REG_BATCH_SIZE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_UPDATE,
        OP_SHIFT
    } cell_op_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        logic     do_insert;
    } cell_cmd_t;

endpackage

>>> rtl/per_second_packet_binning.sv
// ----------------------------------------------------------------------------
// per_second_packet_binning
// Sorted chain of per-second bins; counts packets per arrival second and
// drains the oldest bins as a batch when the table fills to the flush level.
// ----------------------------------------------------------------------------
// An item is taken in S_IDLE (chain updated at the transfer edge), followed
// by a flush check in S_CHECK; if the flush level is reached, S_FLUSH drains
// the batch, loading the head bin into the output register as the chain
// shifts toward cell 0, paced by the single output register (held while it stalls).
// in_stall is high outside S_IDLE, so a new item waits for the check and any flush.
// Reset clears the sequencer, occupancy and config (flush level 20, batch 10);
// the bin cells have no reset and hold data only below the occupancy.
// ----------------------------------------------------------------------------
module per_second_packet_binning
    import pbin_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [SEC_W-1:0] arrival_second,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [SEC_W-1:0] bin_second,
    output logic [CNT_W-1:0] bin_count,
    output logic             last_of_batch
);

    localparam int OW = $clog2(CAPACITY + 1);

    cell_cmd_t        cmd;
    logic [OW-1:0]    occ;
    logic             load_out;
    logic             load_last;
    logic             slot_free;
    logic             match_any;

    logic [SEC_W-1:0] cell_sec   [CAPACITY];
    logic [CNT_W-1:0] cell_cnt   [CAPACITY];
    logic [CAPACITY-1:0] cell_less;
    logic [CAPACITY-1:0] cell_match;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SEC_W-1:0] bin_second_reg;
    logic [CNT_W-1:0] bin_count_reg;
    logic             last_reg;

    assign match_any = |cell_match;
    assign slot_free = !out_valid_reg || !out_stall;

    pbin_ctrl #(
        .CAPACITY (CAPACITY),
        .OW       (OW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .match_any (match_any),
        .slot_free (slot_free),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .occ       (occ),
        .load_out  (load_out),
        .load_last (load_last)
    );

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic             left_less;
            logic [SEC_W-1:0] left_sec;
            logic [CNT_W-1:0] left_cnt;
            logic [SEC_W-1:0] right_sec;
            logic [CNT_W-1:0] right_cnt;

            if (gi == 0)
            begin : g_head
                // head cell: nothing older to its left
                assign left_less = 1'b1;
                assign left_sec  = arrival_second;
                assign left_cnt  = CNT_W'(1);
            end
            else
            begin : g_body
                assign left_less = cell_less[gi-1];
                assign left_sec  = cell_sec[gi-1];
                assign left_cnt  = cell_cnt[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_sec = cell_sec[gi];
                assign right_cnt = cell_cnt[gi];
            end
            else
            begin : g_mid
                assign right_sec = cell_sec[gi+1];
                assign right_cnt = cell_cnt[gi+1];
            end

            pbin_cell u_cell (
                .clk            (clk),
                .cmd            (cmd),
                .valid          (occ > OW'(gi)),
                .arrival_second (arrival_second),
                .left_less      (left_less),
                .left_second    (left_sec),
                .left_count     (left_cnt),
                .right_second   (right_sec),
                .right_count    (right_cnt),
                .second         (cell_sec[gi]),
                .count          (cell_cnt[gi]),
                .less           (cell_less[gi]),
                .match          (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // head of the chain goes out as the chain shifts down
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            bin_second_reg <= cell_sec[0];
            bin_count_reg  <= cell_cnt[0];
            last_reg       <= load_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_second    = bin_second_reg;
    assign bin_count     = bin_count_reg;
    assign last_of_batch = last_reg;

endmodule

>>> rtl/pbin_cell.sv
// ----------------------------------------------------------------------------
// pbin_cell
// One bin of the sorted chain: holds a (second, count) pair, increments on a
// match, takes the new bin or its left neighbor on insert, and takes its right
// neighbor when the chain drains toward the output.
// ----------------------------------------------------------------------------
module pbin_cell
    import pbin_pkg::*;
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic             valid,
    input  logic [SEC_W-1:0] arrival_second,
    input  logic             left_less,
    input  logic [SEC_W-1:0] left_second,
    input  logic [CNT_W-1:0] left_count,
    input  logic [SEC_W-1:0] right_second,
    input  logic [CNT_W-1:0] right_count,
    output logic [SEC_W-1:0] second,
    output logic [CNT_W-1:0] count,
    output logic             less,
    output logic             match
);

    logic [SEC_W-1:0] second_reg;
    logic [SEC_W-1:0] second_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign less   = valid && (second_reg < arrival_second);
    assign match  = valid && (second_reg == arrival_second);
    assign second = second_reg;
    assign count  = count_reg;

    always_comb
    begin
        second_next = second_reg;
        count_next  = count_reg;
        case (cmd.op)
            OP_UPDATE:
            begin
                if (match)
                begin
                    if (count_reg != {CNT_W{1'b1}})
                        count_next = count_reg + 1'b1;
                end
                else if (cmd.do_insert && !less)
                begin
                    // insertion point is where the left neighbor is still older
                    if (left_less)
                    begin
                        second_next = arrival_second;
                        count_next  = CNT_W'(1);
                    end
                    else
                    begin
                        second_next = left_second;
                        count_next  = left_count;
                    end
                end
            end
            OP_SHIFT:
            begin
                second_next = right_second;
                count_next  = right_count;
            end
            default:
            begin
                second_next = second_reg;
                count_next  = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        second_reg <= second_next;
        count_reg  <= count_next;
    end

endmodule

>>> rtl/pbin_ctrl.sv
// ----------------------------------------------------------------------------
// pbin_ctrl
// Sequencer: configuration registers, occupancy, flush decision and batch
// countdown, and the command for the cell chain.
// ----------------------------------------------------------------------------
module pbin_ctrl
    import pbin_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int OW       = $clog2(CAPACITY + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             match_any,
    input  logic             slot_free,
    output logic             in_stall,
    output cell_cmd_t        cmd,
    output logic [OW-1:0]    occ,
    output logic             load_out,
    output logic             load_last
);

    localparam int CMPW = (OW > CFG_W) ? OW : CFG_W;
    localparam logic [CMPW-1:0] CAP_C   = CMPW'(CAPACITY);
    localparam logic [CMPW-1:0] BATCH_C = CMPW'(MAX_BATCH);

    state_t            state_reg;
    state_t            state_next;
    logic [OW-1:0]     occ_reg;
    logic [OW-1:0]     occ_next;
    logic [CMPW-1:0]   remain_reg;
    logic [CMPW-1:0]   remain_next;
    logic [CFG_W-1:0]  flush_occ_reg;
    logic [CFG_W-1:0]  batch_size_reg;

    logic              accept_in;
    logic              full;
    logic              shift_go;
    logic [CMPW-1:0]   occ_ext;
    logic [CMPW-1:0]   flush_eff;
    logic [CMPW-1:0]   batch_eff;

    assign full      = (occ_reg == OW'(CAPACITY));
    assign occ_ext   = CMPW'(occ_reg);
    assign accept_in = (state_reg == S_IDLE) && in_valid;
    assign shift_go  = (state_reg == S_FLUSH) && slot_free;
    assign occ       = occ_reg;

    always_comb
    begin
        flush_eff = CMPW'(flush_occ_reg);
        if (flush_eff < CMPW'(2))
            flush_eff = CMPW'(2);
        if (flush_eff > CAP_C)
            flush_eff = CAP_C;

        batch_eff = CMPW'(batch_size_reg);
        if (batch_eff == '0)
            batch_eff = CMPW'(1);
        if (batch_eff > BATCH_C)
            batch_eff = BATCH_C;
        if (batch_eff > occ_ext)
            batch_eff = occ_ext;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (occ_ext >= flush_eff)
                    state_next = S_FLUSH;
                else
                    state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                if (slot_free && (remain_reg == CMPW'(1)))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        cmd.do_insert = !match_any && !full;
        load_out      = shift_go;
        load_last     = (remain_reg == CMPW'(1));
        occ_next      = occ_reg;
        remain_next   = remain_reg;
        if (accept_in)
            cmd.op = OP_UPDATE;
        else if (shift_go)
            cmd.op = OP_SHIFT;
        else
            cmd.op = OP_HOLD;

        if (accept_in && cmd.do_insert)
            occ_next = occ_reg + 1'b1;
        else if (shift_go)
            occ_next = occ_reg - 1'b1;

        if (state_reg == S_CHECK)
            remain_next = batch_eff;
        else if (shift_go)
            remain_next = remain_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            occ_reg        <= '0;
            remain_reg     <= '0;
            flush_occ_reg  <= FLUSH_OCC_RST;
            batch_size_reg <= BATCH_SIZE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            remain_reg <= remain_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_FLUSH_OCC)
                    flush_occ_reg <= cfg_data;
                else
                    batch_size_reg <= cfg_data;
            end
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_ext <= CAP_C)
        else $error("occupancy above capacity");

    a_flush_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (remain_reg != '0) && (remain_reg <= occ_ext))
        else $error("flush countdown out of range");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == S_CHECK))
        else $error("accepted item not followed by flush check");

    a_shift_occ: assert property (@(posedge clk) disable iff (!rst_n)
        shift_go |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("drain did not drop occupancy");

endmodule
